// ===== src/ykf_pkg.sv =====
// Shared constants and helpers for the yaw-rate Kalman integrator.
// No dependencies; imported by ykf_mul, ykf_div and the top level.
`default_nettype none

package ykf_pkg;

    localparam int unsigned FILT_W     = 48;
    localparam int unsigned YAW_W      = 42;
    localparam int unsigned OUT_FRAC   = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 47;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZERO_OFFSET = 3'd0,
        REG_TIME_STEP   = 3'd1,
        REG_Q_ANGLE     = 3'd2,
        REG_Q_BIAS      = 3'd3,
        REG_MEAS_NOISE  = 3'd4,
        REG_RATE_SCALE  = 3'd5
    } t_reg_idx;

    // Clamp a magnitude to the signed range given by max_pos, then apply the sign.
    function automatic logic [63:0] sat_signed(input logic [63:0] mag_in, input logic neg,
                                               input logic [63:0] max_pos);
        logic [63:0] lim;
        logic [63:0] m;
        lim = neg ? (max_pos + 64'd1) : max_pos;
        m   = (mag_in > lim) ? lim : mag_in;
        return neg ? (~m + 64'd1) : m;
    endfunction

endpackage

`default_nettype wire

// ===== src/ykf_mul.sv =====
// Bit-serial fixed point multiplier: one multiplier bit per cycle, round, saturate.
// Depends on ykf_pkg (sat_signed).
`default_nettype none

module ykf_mul import ykf_pkg::*; #(
    parameter int W = 48,
    parameter int F = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [W-1:0]  i_a,
    input  wire signed [W-1:0]  i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_result
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_state;

    localparam int CW = $clog2(W + 1);
    localparam int QW = 2 * W - F + 1;
    localparam int QX = (QW > 64) ? QW : 65;
    localparam logic [63:0] MAX_POS = (64'd1 << (W - 1)) - 64'd1;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_mcand, r_mplier, r_hi, r_lo;
    logic            r_neg, r_done;
    logic signed [W-1:0] r_result;

    logic [W-1:0]    w_ua, w_ub;
    logic [W:0]      w_sum;
    logic [2*W-1:0]  w_prod;
    logic [QW-1:0]   w_q;
    logic [QX-1:0]   w_qx;
    logic [63:0]     w_mag, w_sat;

    assign w_ua   = i_a[W-1] ? unsigned'(-i_a) : unsigned'(i_a);
    assign w_ub   = i_b[W-1] ? unsigned'(-i_b) : unsigned'(i_b);
    assign w_sum  = {1'b0, r_hi} + (r_mplier[0] ? {1'b0, r_mcand} : {(W+1){1'b0}});
    assign w_prod = {r_hi, r_lo};
    // round half away from zero on the magnitude
    assign w_q    = QW'(w_prod[2*W-1:F]) + QW'(w_prod[F-1]);
    assign w_qx   = QX'(w_q);
    assign w_mag  = (|w_qx[QX-1:64]) ? {64{1'b1}} : w_qx[63:0];
    assign w_sat  = sat_signed(w_mag, r_neg, MAX_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_mcand  <= w_ua;
                        r_mplier <= w_ub;
                        r_hi     <= '0;
                        r_lo     <= '0;
                        r_cnt    <= '0;
                        r_neg    <= i_a[W-1] ^ i_b[W-1];
                        r_state  <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_hi     <= w_sum[W:1];
                    r_lo     <= {w_sum[0], r_lo[W-1:1]};
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_result <= W'(w_sat);
                    r_done   <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== src/ykf_div.sv =====
// Bit-serial restoring divider for fixed point quotients, truncating, saturated.
// Depends on ykf_pkg (sat_signed).
`default_nettype none

module ykf_div import ykf_pkg::*; #(
    parameter int W = 48,
    parameter int F = 32
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  wire signed [W-1:0]  i_num,
    input  wire signed [W-1:0]  i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_result
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} t_state;

    localparam int CW = $clog2(W + 1);
    localparam int SH = W - F;
    localparam logic [63:0] MAX_POS = (64'd1 << (W - 1)) - 64'd1;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [W-1:0]    r_ub, r_rem, r_dvd, r_q;
    logic            r_neg, r_zero, r_ovf, r_done;
    logic signed [W-1:0] r_result;

    logic [W-1:0]    w_ua, w_ub;
    logic [W:0]      w_t;
    logic            w_ge;
    logic [63:0]     w_mag;

    assign w_ua  = i_num[W-1] ? unsigned'(-i_num) : unsigned'(i_num);
    assign w_ub  = i_den[W-1] ? unsigned'(-i_den) : unsigned'(i_den);
    assign w_t   = {r_rem, r_dvd[W-1]};
    assign w_ge  = (w_t >= {1'b0, r_ub});
    assign w_mag = r_zero ? 64'd0 : (r_ovf ? {64{1'b1}} : 64'(r_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_ub    <= w_ub;
                        r_rem   <= w_ua >> SH;
                        r_dvd   <= {w_ua[SH-1:0], {F{1'b0}}};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_neg   <= i_num[W-1] ^ i_den[W-1];
                        r_zero  <= (w_ua == '0);
                        // quotient would not fit in W bits (also covers a zero divisor)
                        r_ovf   <= ((w_ua >> SH) >= w_ub);
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_rem   <= w_ge ? W'(w_t - {1'b0, r_ub}) : W'(w_t);
                    r_q     <= {r_q[W-2:0], w_ge};
                    r_dvd   <= r_dvd << 1;
                    r_cnt   <= r_cnt + CW'(1);
                    if (r_cnt == CW'(W - 1)) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_result <= W'(sat_signed(w_mag, r_neg, MAX_POS));
                    r_done   <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== src/yaw_rate_kalman_integrator.sv =====
// Per input beat, W = 16+FRAC_BITS: eleven serial multiplies and two serial divides run
//   one after another; one sample is in flight at a time, and the output register
//   frees the input side.
// Reset (synchronous, active low): filter state cleared, covariance to identity,
//   configuration registers to their defaults, no beat pending.
`default_nettype none

module yaw_rate_kalman_integrator import ykf_pkg::*; #(
    parameter int FRAC_BITS = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [15:0]           s_axis_tdata,   // [15:0] raw_rate
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [95:0]           m_axis_tdata,   // [47:0] filtered_rate, [89:48] yaw_degrees
    input  wire                   i_cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int W  = 16 + FRAC_BITS;   // internal Q16.FRAC_BITS word
    localparam int XW = W + 4;            // headroom for sums before saturation
    localparam int FQ_SHL = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
    localparam int FQ_SHR = (FRAC_BITS < 32)  ? 32 - FRAC_BITS : 0;
    localparam logic [63:0] MAX_POS64 = (64'd1 << (W - 1)) - 64'd1;
    localparam logic [63:0] Q47_MAX   = (64'd1 << 47) - 64'd1;
    localparam logic signed [XW-1:0] X_MAX = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] X_MIN = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [W-1:0]  FX_ONE   = W'(64'd1 << FRAC_BITS);
    localparam logic signed [XW-1:0] YAW_WRAP = XW'(64'd360 << FRAC_BITS);

    // Sequencer: each multiply or divide step waits for its serial unit to finish.
    typedef enum logic [3:0] {
        ST_IDLE, ST_PRED, ST_P00, ST_PDT, ST_SUMS, ST_K0, ST_K1, ST_EST,
        ST_BIAS, ST_C00, ST_C01, ST_C10, ST_C11, ST_DEG, ST_YAW, ST_OUT
    } t_state;

    function automatic logic signed [W-1:0] sat_x(input logic signed [XW-1:0] v);
        if (v > X_MAX) return X_MAX[W-1:0];
        if (v < X_MIN) return X_MIN[W-1:0];
        return v[W-1:0];
    endfunction

    // Q0.32 / Q16.32 register to internal format
    function automatic logic signed [W-1:0] from_q32(input logic [46:0] v);
        logic [63:0] e;
        e = (64'(v) << FQ_SHL) >> FQ_SHR;
        return (e > MAX_POS64) ? MAX_POS64[W-1:0] : e[W-1:0];
    endfunction

    // internal format to Q16.32, truncating toward zero
    function automatic logic [63:0] to_q32(input logic signed [W-1:0] v);
        logic [63:0] m;
        m = v[W-1] ? 64'(unsigned'(-v)) : 64'(unsigned'(v));
        m = (m >> FQ_SHL) << FQ_SHR;
        return sat_signed(m, v[W-1], Q47_MAX);
    endfunction

    // configuration
    logic signed [15:0] r_zero_off;
    logic [31:0]        r_time_step, r_q_angle, r_q_bias, r_rate_scale;
    logic [46:0]        r_meas_noise;

    // filter state
    t_state             r_state;
    logic               r_go, r_seeded, r_m_valid;
    logic signed [16:0] r_prev;
    logic signed [W-1:0] r_est, r_bias, r_c00, r_c01, r_c10, r_c11, r_yaw;
    // per-sample working values
    logic signed [W-1:0] r_meas, r_rate, r_p00, r_p01, r_p10, r_p11;
    logic signed [W-1:0] r_s, r_k0, r_k1, r_y, r_deg;
    logic [FILT_W-1:0]  r_out_filt;
    logic [YAW_W-1:0]   r_out_yaw;

    logic signed [W-1:0]  w_dt, w_qa, w_qb, w_rn, w_scale;
    logic signed [16:0]   w_gz;
    logic signed [17:0]   w_diff;
    logic signed [W-1:0]  w_mul_a, w_mul_b, w_mul_res, w_div_res;
    logic signed [XW-1:0] w_yaw_sum;
    logic                 w_is_mul, w_is_div, w_mul_start, w_div_start;
    logic                 w_mul_done, w_div_done, w_accept;

    assign w_dt    = from_q32(47'(r_time_step));
    assign w_qa    = from_q32(47'(r_q_angle));
    assign w_qb    = from_q32(47'(r_q_bias));
    assign w_rn    = from_q32(r_meas_noise);
    assign w_scale = from_q32(47'(r_rate_scale));

    assign w_gz    = 17'(signed'(s_axis_tdata)) - 17'(r_zero_off);
    assign w_diff  = 18'(w_gz) - 18'(r_prev);
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign w_is_mul = r_state inside {ST_PRED, ST_P00, ST_PDT, ST_EST, ST_BIAS, ST_C00,
                                      ST_C01, ST_C10, ST_C11, ST_DEG, ST_YAW};
    assign w_is_div = r_state inside {ST_K0, ST_K1};
    assign w_mul_start = r_go && w_is_mul;
    assign w_div_start = r_go && w_is_div;

    assign w_yaw_sum = XW'(r_yaw) + XW'(w_mul_res);

    // multiplier operand select per step
    always_comb begin
        case (r_state)
            ST_PRED: begin w_mul_a = sat_x(XW'(r_rate) - XW'(r_bias)); w_mul_b = w_dt;  end
            ST_P00:  begin w_mul_a = sat_x(XW'(r_c01) + XW'(r_c10));   w_mul_b = w_dt;  end
            ST_PDT:  begin w_mul_a = r_c11; w_mul_b = w_dt;    end
            ST_EST:  begin w_mul_a = r_k0;  w_mul_b = r_y;     end
            ST_BIAS: begin w_mul_a = r_k1;  w_mul_b = r_y;     end
            ST_C00:  begin w_mul_a = r_k0;  w_mul_b = r_p00;   end
            ST_C01:  begin w_mul_a = r_k0;  w_mul_b = r_p01;   end
            ST_C10:  begin w_mul_a = r_k1;  w_mul_b = r_p00;   end
            ST_C11:  begin w_mul_a = r_k1;  w_mul_b = r_p01;   end
            ST_DEG:  begin w_mul_a = r_est; w_mul_b = w_scale; end
            ST_YAW:  begin w_mul_a = r_deg; w_mul_b = w_dt;    end
            default: begin w_mul_a = '0;    w_mul_b = '0;      end
        endcase
    end

    ykf_mul #(.W(W), .F(FRAC_BITS)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_a      (w_mul_a),
        .i_b      (w_mul_b),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    // both gains share the innovation variance as divisor
    ykf_div #(.W(W), .F(FRAC_BITS)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    ((r_state == ST_K1) ? r_p10 : r_p00),
        .i_den    (r_s),
        .o_done   (w_div_done),
        .o_result (w_div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_off   <= '0;
            r_time_step  <= 32'd21474836;
            r_q_angle    <= 32'd4295;
            r_q_bias     <= 32'd214748365;
            r_meas_noise <= 47'd34359738368;
            r_rate_scale <= 32'd261888250;
            r_state      <= ST_IDLE;
            r_go         <= 1'b0;
            r_seeded     <= 1'b0;
            r_m_valid    <= 1'b0;
            r_prev       <= '0;
            r_est        <= '0;
            r_bias       <= '0;
            r_c00        <= FX_ONE;
            r_c01        <= '0;
            r_c10        <= '0;
            r_c11        <= FX_ONE;
            r_yaw        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_ZERO_OFFSET: r_zero_off   <= signed'(i_cfg_data[15:0]);
                    REG_TIME_STEP:   r_time_step  <= i_cfg_data[31:0];
                    REG_Q_ANGLE:     r_q_angle    <= i_cfg_data[31:0];
                    REG_Q_BIAS:      r_q_bias     <= i_cfg_data[31:0];
                    REG_MEAS_NOISE:  r_meas_noise <= i_cfg_data;
                    REG_RATE_SCALE:  r_rate_scale <= i_cfg_data[31:0];
                    default: ;   // unknown index: ignored
                endcase
            end

            r_go <= 1'b0;
            // ST_OUT handles the output register itself
            if (m_axis_tready && (r_state != ST_OUT)) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_meas <= sat_x(XW'(w_gz) <<< FRAC_BITS);
                        r_rate <= sat_x(XW'(w_diff) <<< FRAC_BITS);
                        r_prev <= w_gz;
                        // first sample seeds the estimate
                        if (!r_seeded) begin
                            r_est    <= sat_x(XW'(w_gz) <<< FRAC_BITS);
                            r_bias   <= '0;
                            r_seeded <= 1'b1;
                        end
                        r_go    <= 1'b1;
                        r_state <= ST_PRED;
                    end
                end
                ST_PRED: if (w_mul_done) begin
                    r_est   <= sat_x(XW'(r_est) + XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_P00;
                end
                ST_P00: if (w_mul_done) begin
                    r_p00   <= sat_x(XW'(r_c00) + XW'(w_qa) - XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_PDT;
                end
                ST_PDT: if (w_mul_done) begin
                    r_p01   <= sat_x(XW'(r_c01) - XW'(w_mul_res));
                    r_p10   <= sat_x(XW'(r_c10) - XW'(w_mul_res));
                    r_state <= ST_SUMS;
                end
                ST_SUMS: begin
                    r_p11   <= sat_x(XW'(r_c11) + XW'(w_qb));
                    r_s     <= sat_x(XW'(r_p00) + XW'(w_rn));
                    r_y     <= sat_x(XW'(r_meas) - XW'(r_est));
                    r_go    <= 1'b1;
                    r_state <= ST_K0;
                end
                ST_K0: if (w_div_done) begin
                    r_k0    <= w_div_res;
                    r_go    <= 1'b1;
                    r_state <= ST_K1;
                end
                ST_K1: if (w_div_done) begin
                    r_k1    <= w_div_res;
                    r_go    <= 1'b1;
                    r_state <= ST_EST;
                end
                ST_EST: if (w_mul_done) begin
                    r_est   <= sat_x(XW'(r_est) + XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_BIAS;
                end
                ST_BIAS: if (w_mul_done) begin
                    r_bias  <= sat_x(XW'(r_bias) + XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_C00;
                end
                // covariance update uses the predicted values only
                ST_C00: if (w_mul_done) begin
                    r_c00   <= sat_x(XW'(r_p00) - XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_C01;
                end
                ST_C01: if (w_mul_done) begin
                    r_c01   <= sat_x(XW'(r_p01) - XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_C10;
                end
                ST_C10: if (w_mul_done) begin
                    r_c10   <= sat_x(XW'(r_p10) - XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_C11;
                end
                ST_C11: if (w_mul_done) begin
                    r_c11   <= sat_x(XW'(r_p11) - XW'(w_mul_res));
                    r_go    <= 1'b1;
                    r_state <= ST_DEG;
                end
                ST_DEG: if (w_mul_done) begin
                    r_deg   <= w_mul_res;
                    r_go    <= 1'b1;
                    r_state <= ST_YAW;
                end
                ST_YAW: if (w_mul_done) begin
                    // wrap to zero at +/-360 degrees
                    if (XW'(sat_x(w_yaw_sum)) >= YAW_WRAP ||
                        XW'(sat_x(w_yaw_sum)) <= -YAW_WRAP) begin
                        r_yaw <= '0;
                    end else begin
                        r_yaw <= sat_x(w_yaw_sum);
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // output register: wait only while an older beat is still held
                    if (!r_m_valid || m_axis_tready) begin
                        r_out_filt <= FILT_W'(to_q32(r_est));
                        r_out_yaw  <= YAW_W'(to_q32(r_yaw));
                        r_m_valid  <= 1'b1;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_out_yaw, r_out_filt};

`ifndef SYNTHESIS
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_mul_start && w_div_start))
        else $error("multiplier and divider started together");

    a_mul_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> w_is_mul)
        else $error("multiplier result outside a multiply step");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> w_is_div)
        else $error("divider result outside a gain step");

    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (XW'(r_yaw) < YAW_WRAP) && (XW'(r_yaw) > -YAW_WRAP))
        else $error("yaw accumulator escaped the wrap range");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_yaw_rate_kalman_integrator.sv =====
// Self-checking testbench for yaw_rate_kalman_integrator: random gyro samples and
// register settings, a bit-exact filter predictor and an in-order scoreboard.
// Depends on ykf_pkg and the block's RTL in src.
`timescale 1ns / 1ps

module tb_yaw_rate_kalman_integrator import ykf_pkg::*;;

    localparam longint VAL_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam longint VAL_MIN = -(64'sd1 <<< 47);
    localparam longint FX_360  = 64'sd360 <<< 32;
    localparam int     SETTLE  = 700;   // a bit more than one sample's latency

    typedef struct {
        logic [FILT_W-1:0] filt;
        logic [YAW_W-1:0]  yaw;
    } t_yaw_beat;

    // Filter predictor plus queue of expected output beats
    class yaw_scoreboard;
        logic [63:0] regs [6];
        longint est, bias, yaw_acc, prev_gz;
        longint cov [4];
        bit seeded;
        t_yaw_beat pending [$];
        int errors;

        function new();
            regs[REG_ZERO_OFFSET] = 64'd0;
            regs[REG_TIME_STEP]   = 64'd21474836;
            regs[REG_Q_ANGLE]     = 64'd4295;
            regs[REG_Q_BIAS]      = 64'd214748365;
            regs[REG_MEAS_NOISE]  = 64'd34359738368;
            regs[REG_RATE_SCALE]  = 64'd261888250;
            est = 0; bias = 0; yaw_acc = 0; prev_gz = 0; seeded = 0;
            cov[0] = 64'sd1 <<< 32; cov[1] = 0; cov[2] = 0; cov[3] = 64'sd1 <<< 32;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ZERO_OFFSET: regs[idx] = {48'd0, val[15:0]};
                REG_TIME_STEP, REG_Q_ANGLE, REG_Q_BIAS, REG_RATE_SCALE:
                    regs[idx] = {32'd0, val[31:0]};
                REG_MEAS_NOISE:  regs[idx] = {17'd0, val};
                default: ;  // unknown index: ignored
            endcase
        endfunction

        function longint clip(longint v);
            return (v > VAL_MAX) ? VAL_MAX : ((v < VAL_MIN) ? VAL_MIN : v);
        endfunction

        function logic [63:0] absval(longint v);
            return (v < 0) ? 64'(-v) : 64'(v);
        endfunction

        function longint signed_mag(logic [63:0] m, bit neg);
            logic [63:0] lim;
            lim = neg ? 64'd1 << 47 : (64'd1 << 47) - 64'd1;
            if (m > lim) m = lim;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // Q16.32 product, round half away from zero, saturating
        function longint qmul(longint a, longint b);
            logic [127:0] p;
            bit neg;
            neg = (a < 0) != (b < 0);
            p = {64'd0, absval(a)} * {64'd0, absval(b)} + (128'd1 << 31);
            if ((p >> 96) != 0) return signed_mag(64'd1 << 47, neg);
            return signed_mag(p[95:32], neg);
        endfunction

        // Q16.32 quotient, truncating toward zero, saturating
        function longint qdiv(longint a, longint b);
            logic [63:0] ua, ub;
            logic [127:0] q;
            bit neg;
            if (b == 0) return (a == 0) ? 0 : ((a > 0) ? VAL_MAX : VAL_MIN);
            neg = (a < 0) != (b < 0);
            ua = absval(a);
            ub = absval(b);
            if ((ua >> 32) >= ub) return signed_mag(64'd1 << 47, neg);
            q = {32'd0, ua, 32'd0} / {64'd0, ub};
            return signed_mag(q[63:0], neg);
        endfunction

        function void note_sample(logic [15:0] raw);
            longint gz, meas, rate, dt, qa, qb, rn, scale;
            longint p00, p01, p10, p11, s, k0, k1, y, deg;
            t_yaw_beat exp_beat;
            gz    = longint'($signed(raw)) - longint'($signed(regs[REG_ZERO_OFFSET][15:0]));
            meas  = clip(gz <<< 32);
            rate  = clip((gz - prev_gz) <<< 32);
            dt    = clip(longint'(regs[REG_TIME_STEP]));
            qa    = clip(longint'(regs[REG_Q_ANGLE]));
            qb    = clip(longint'(regs[REG_Q_BIAS]));
            rn    = clip(longint'(regs[REG_MEAS_NOISE]));
            scale = clip(longint'(regs[REG_RATE_SCALE]));
            prev_gz = gz;
            if (!seeded) begin
                est = meas;
                bias = 0;
                seeded = 1;
            end
            // predict
            est = clip(est + qmul(clip(rate - bias), dt));
            p00 = clip(cov[0] + qa - qmul(clip(cov[1] + cov[2]), dt));
            p01 = clip(cov[1] - qmul(cov[3], dt));
            p10 = clip(cov[2] - qmul(cov[3], dt));
            p11 = clip(cov[3] + qb);
            // gains
            s  = clip(p00 + rn);
            k0 = qdiv(p00, s);
            k1 = qdiv(p10, s);
            // update from the predicted covariance
            y    = clip(meas - est);
            est  = clip(est + qmul(k0, y));
            bias = clip(bias + qmul(k1, y));
            cov[0] = clip(p00 - qmul(k0, p00));
            cov[1] = clip(p01 - qmul(k0, p01));
            cov[2] = clip(p10 - qmul(k1, p00));
            cov[3] = clip(p11 - qmul(k1, p01));
            // yaw integration with wrap at +/-360 degrees
            deg = qmul(est, scale);
            yaw_acc = clip(yaw_acc + qmul(deg, dt));
            if (yaw_acc >= FX_360 || yaw_acc <= -FX_360) yaw_acc = 0;
            exp_beat.filt = est[FILT_W-1:0];
            exp_beat.yaw  = yaw_acc[YAW_W-1:0];
            pending.push_back(exp_beat);
        endfunction

        function void check_beat(logic [95:0] data);
            t_yaw_beat e;
            if (pending.size() == 0) begin
                $error("output beat with no sample pending: %h", data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[47:0] !== e.filt) begin
                $error("filtered_rate: expected %h, got %h", e.filt, data[47:0]);
                errors++;
            end
            if (data[89:48] !== e.yaw) begin
                $error("yaw_degrees: expected %h, got %h", e.yaw, data[89:48]);
                errors++;
            end
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic m_axis_tvalid, m_axis_tready;
    logic [95:0] m_axis_tdata;
    logic i_cfg_wr_en;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    yaw_rate_kalman_integrator DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    yaw_scoreboard sb = new();

    int tx_idle_pct = 0;     // sender idle chance per cycle, percent
    int rx_idle_pct = 0;     // receiver idle chance per cycle, percent
    int rx_hold_cycles = 0;  // long receiver hold-off, counted down below
    logic [15:0] drift = 16'd0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_yaw_rate_kalman_integrator: done, errors");
        $finish;
    end

    // Receiver: random stalls, or a long hold-off while the sender keeps pushing
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles <= rx_hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Beat monitors: sampled values are the pre-edge ones
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_sample(logic [15:0] raw);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= raw;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Wait for every expected beat, then a latency's worth of quiet
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Mostly slow-moving gyro traces, with noise, full-scale steps and rails
    function automatic logic [15:0] next_raw();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                drift = drift + 16'($signed($urandom_range(64)) - 32);
                return drift + 16'($urandom_range(15));
            end
            5, 6: return 16'($urandom);
            7:    return 16'h7fff;
            8:    return 16'h8000;
            default: return drift;
        endcase
    endfunction

    task automatic random_config(int kind);
        logic [CFG_DATA_W-1:0] r;
        for (int i = 0; i < 6; i++) begin
            case (kind)
                0: r = '0;
                1: r = '1;
                default: begin
                    r = {15'($urandom_range(32767)), $urandom};
                    if (i == REG_TIME_STEP) r = CFG_DATA_W'($urandom_range(1 << 28));
                    else if (i != REG_MEAS_NOISE) r = {15'd0, $urandom};
                end
            endcase
            cfg_write(i[CFG_IDX_W-1:0], r);
        end
        // unknown indexes must leave everything alone
        cfg_write(3'd6, CFG_DATA_W'({$urandom, $urandom}));
        cfg_write(3'd7, CFG_DATA_W'({$urandom, $urandom}));
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: defaults, rails, zero, alternating extremes
        tx_idle_pct = 9;
        rx_idle_pct = 55;
        send_sample(16'h7fff);
        repeat (4) send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        drain();
        // offset at the rail: corrected sample leaves the format range
        cfg_write(REG_ZERO_OFFSET, 47'h8000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        drain();
        cfg_write(REG_ZERO_OFFSET, 47'h7fff);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        drain();
        // no noise at all: innovation variance can collapse to zero
        random_config(0);
        repeat (4) send_sample(16'($urandom));
        drain();
        // everything at full scale: negative variance, saturated gains
        random_config(1);
        repeat (4) send_sample(16'($urandom));
        drain();

        // Random phases: config changes only once idle
        for (int ph = 0; ph < 6; ph++) begin
            if (ph < 2) begin
                tx_idle_pct = 9; rx_idle_pct = 55;
            end else if (ph < 4) begin
                tx_idle_pct = 55; rx_idle_pct = 9;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            if (ph == 0 || ph == 5) begin
                cfg_write(REG_ZERO_OFFSET, 47'd0);
                cfg_write(REG_TIME_STEP, 47'd21474836);
                cfg_write(REG_Q_ANGLE, 47'd4295);
                cfg_write(REG_Q_BIAS, 47'd214748365);
                cfg_write(REG_MEAS_NOISE, 47'd34359738368);
                cfg_write(REG_RATE_SCALE, 47'd261888250);
            end else begin
                random_config(ph == 3 ? 1 : 2);
            end
            for (int n = 0; n < 215; n++) begin
                if (n == 20 && ph == 4) rx_hold_cycles = 3000;
                if (n == 100 && ph == 1) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                send_sample(next_raw());
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_yaw_rate_kalman_integrator: done, clean");
        end else begin
            $display("tb_yaw_rate_kalman_integrator: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
src/ykf_pkg.sv
src/ykf_mul.sv
src/ykf_div.sv
src/yaw_rate_kalman_integrator.sv
sim/tb_yaw_rate_kalman_integrator.sv
